FILE: design/mac_pkg.sv
package mac_pkg;

  localparam int QTY_W     = 12;
  localparam int QSTEP_W   = $clog2(QTY_W);
  localparam int WIN_REG_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [QTY_W-1:0] QTY_TEN = 12'd2560;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 2'd1;

  localparam logic [WIN_REG_W-1:0] SHORT_WINDOW_RST = 7'd5;
  localparam logic [WIN_REG_W-1:0] LONG_WINDOW_RST  = 7'd20;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef struct packed {
    logic shift_in;
    logic rotate;
  } cell_ctrl_t;

endpackage

FILE: design/mac_cell.sv
module mac_cell #(
  parameter int PRICE_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_pkg::cell_ctrl_t     ctrl,
  input  logic [PRICE_BITS-1:0]   from_prev,
  input  logic [PRICE_BITS-1:0]   from_next,
  output logic [PRICE_BITS-1:0]   price
);

  logic [PRICE_BITS-1:0] price_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      price_r <= '0;
    end else if (ctrl.shift_in) begin
      price_r <= from_prev;
    end else if (ctrl.rotate) begin
      price_r <= from_next;
    end
  end

  assign price = price_r;

endmodule

FILE: design/mac_divider.sv
module mac_divider #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          numerator,
  input  logic [DEN_W-1:0]          denominator,
  output logic                      done,
  output logic [mac_pkg::QTY_W-1:0] quotient
);

  localparam int DSH_W = DEN_W + mac_pkg::QTY_W - 1;
  localparam int CMP_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;

  logic                          busy_r;
  logic                          done_r;
  logic [mac_pkg::QSTEP_W-1:0]   step_r;
  logic [NUM_W-1:0]              rem_r;
  logic [DSH_W-1:0]              dsh_r;
  logic [mac_pkg::QTY_W-1:0]     q_r;
  logic                          fits;

  // quotient is known to stay below 2**QTY_W, so QTY_W trial subtractions do
  assign fits = CMP_W'(rem_r) >= CMP_W'(dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= mac_pkg::QSTEP_W'(mac_pkg::QTY_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numerator;
      dsh_r <= DSH_W'(denominator) << (mac_pkg::QTY_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - NUM_W'(dsh_r);
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[mac_pkg::QTY_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: design/moving_average_crossover_signal.sv
// Moving-average crossover signal. Each price item is shifted into a row of
// HISTORY_DEPTH price cells (newest at the head), then the row is rotated once
// round, so every stored price passes the head cell, where the short and long
// window sums and the two rank counts build up. The averages are compared by
// cross-multiplying and, on a buy or sell, the new held quantity comes from a
// shift-subtract divider giving 12 quotient bits. An item goes through the
// rotation of the cell row, a multiply step, a compare step and, when a
// trade fires, the divider. One item is worked on at a time; a
// finished result waits in the output register while the next item is taken.
// Windows of 0 act as 1 and windows above HISTORY_DEPTH act as HISTORY_DEPTH;
// config writes are taken only while no item is being worked on.
module moving_average_crossover_signal #(
  parameter int HISTORY_DEPTH = 64,
  parameter int PRICE_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PRICE_BITS-1:0]         in_price,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_action,
  output logic [mac_pkg::QTY_W-1:0]     out_trade_quantity,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mac_pkg::WIN_REG_W-1:0] cfg_data
);

  localparam int D      = HISTORY_DEPTH;
  localparam int KW     = $clog2(D);
  localparam int CNT_W  = $clog2(D + 1);
  localparam int SUM_W  = PRICE_BITS + KW;
  localparam int PROD_W = SUM_W + CNT_W;
  localparam int NUM_W  = mac_pkg::QTY_W + CNT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROT  = 6'b000010,
    S_MUL  = 6'b000100,
    S_CMP  = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  function automatic logic [CNT_W-1:0] clamp_window(input logic [mac_pkg::WIN_REG_W-1:0] w);
    logic [CNT_W-1:0] r;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (32'(w) > 32'(D)) begin
      r = CNT_W'(D);
    end else begin
      r = CNT_W'(w);
    end
    return r;
  endfunction

  state_t                         state_r, state_nxt;
  logic [mac_pkg::WIN_REG_W-1:0]  short_window_r, long_window_r;
  logic [CNT_W-1:0]               stored_r;
  logic [KW-1:0]                  k_r;
  logic [PRICE_BITS-1:0]          today_r;
  logic [SUM_W-1:0]               ssum_r, lsum_r;
  logic [CNT_W-1:0]               cnt_ge_r, cnt_le_r;
  logic [PROD_W-1:0]              lhs_r, rhs_r;
  logic                           ready_to_buy_r;
  logic [mac_pkg::QTY_W-1:0]      held_r;
  mac_pkg::action_t               action_r;
  logic                           out_valid_r;
  mac_pkg::action_t               out_action_r;
  logic [mac_pkg::QTY_W-1:0]      out_qty_r;

  logic [CNT_W-1:0]               sw_eff, lw_eff;
  logic                           in_acc;
  mac_pkg::cell_ctrl_t            cell_ctrl;
  logic [PRICE_BITS-1:0]          cell_q [D];
  logic [PRICE_BITS-1:0]          head;
  logic [CNT_W-1:0]               k_ext;

  logic                           div_start;
  logic [NUM_W-1:0]               div_num;
  logic                           div_done;
  logic [mac_pkg::QTY_W-1:0]      div_q;
  logic                           buy_now, sell_now;

  assign sw_eff    = clamp_window(short_window_r);
  assign lw_eff    = clamp_window(long_window_r);
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign head      = cell_q[0];
  assign k_ext     = CNT_W'(k_r);

  assign cell_ctrl.shift_in = in_acc;
  assign cell_ctrl.rotate   = (state_r == S_ROT);

  for (genvar g = 0; g < D; g++) begin : g_cell
    if (g == 0) begin : g_head
      mac_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .from_prev (in_price),
        .from_next (cell_q[1]),
        .price     (cell_q[0])
      );
    end else if (g == D - 1) begin : g_tail
      mac_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .from_prev (cell_q[g-1]),
        .from_next (cell_q[0]),
        .price     (cell_q[g])
      );
    end else begin : g_mid
      mac_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .from_prev (cell_q[g-1]),
        .from_next (cell_q[g+1]),
        .price     (cell_q[g])
      );
    end
  end

  assign buy_now  = (lhs_r > rhs_r) && ready_to_buy_r;
  assign sell_now = (lhs_r < rhs_r) && !ready_to_buy_r;

  assign div_start = (state_r == S_CMP) && (buy_now || sell_now);
  assign div_num   = NUM_W'(buy_now ? cnt_ge_r : cnt_le_r) * NUM_W'(mac_pkg::QTY_TEN);

  mac_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .numerator   (div_num),
    .denominator (stored_r),
    .done        (div_done),
    .quotient    (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_ROT;
      S_ROT:   if (k_r == KW'(D - 1)) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CMP;
      S_CMP:   state_nxt = (buy_now || sell_now) ? S_DIV : S_FIN;
      S_DIV:   if (div_done) state_nxt = S_FIN;
      S_FIN:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      short_window_r <= mac_pkg::SHORT_WINDOW_RST;
      long_window_r  <= mac_pkg::LONG_WINDOW_RST;
      stored_r       <= '0;
      k_r            <= '0;
      ready_to_buy_r <= 1'b1;
      held_r         <= mac_pkg::QTY_TEN;
      action_r       <= mac_pkg::ACT_NONE;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mac_pkg::REG_SHORT_WINDOW: short_window_r <= cfg_data;
          mac_pkg::REG_LONG_WINDOW:  long_window_r  <= cfg_data;
          default: ;
        endcase
      end
      if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          k_r <= '0;
          if (in_acc && (stored_r < CNT_W'(D))) begin
            stored_r <= stored_r + 1'b1;
          end
        end
        S_ROT: begin
          k_r <= k_r + 1'b1;
        end
        S_CMP: begin
          if (buy_now) begin
            action_r       <= mac_pkg::ACT_BUY;
            ready_to_buy_r <= 1'b0;
          end else if (sell_now) begin
            action_r       <= mac_pkg::ACT_SELL;
            ready_to_buy_r <= 1'b1;
          end else begin
            action_r <= mac_pkg::ACT_NONE;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            if (action_r != mac_pkg::ACT_NONE) begin
              held_r <= div_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // window sums and rank counts build up as the row rotates past the head
  always_ff @(posedge clk) begin
    if (in_acc) begin
      today_r  <= in_price;
      ssum_r   <= '0;
      lsum_r   <= '0;
      cnt_ge_r <= '0;
      cnt_le_r <= '0;
    end else if (state_r == S_ROT) begin
      if (k_ext < sw_eff) ssum_r <= ssum_r + SUM_W'(head);
      if (k_ext < lw_eff) lsum_r <= lsum_r + SUM_W'(head);
      if (k_ext < stored_r) begin
        if (head >= today_r) cnt_ge_r <= cnt_ge_r + 1'b1;
        if (head <= today_r) cnt_le_r <= cnt_le_r + 1'b1;
      end
    end
    if (state_r == S_MUL) begin
      lhs_r <= PROD_W'(ssum_r) * PROD_W'(lw_eff);
      rhs_r <= PROD_W'(lsum_r) * PROD_W'(sw_eff);
    end
    if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
      out_action_r <= action_r;
      out_qty_r    <= held_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_action_r;
  assign out_trade_quantity = out_qty_r;

endmodule
